@@ rtl/core/tbv_pkg.sv @@
`default_nettype none

package tbv_pkg;

  localparam int unsigned NumBins  = 15;
  localparam int unsigned BinW     = 4;
  localparam int unsigned CountW   = 12;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned ThrW     = 12;
  localparam int unsigned BandW    = 15;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned DataW    = 32;

  localparam int unsigned NumSteep = 7;
  localparam int unsigned NumMid   = 6;

  typedef logic [BinW-1:0]   bin_t;
  typedef logic [CountW-1:0] count_t;

  localparam count_t CountMax = '1;

  localparam logic [SampleW-1:0] IgnoreFrom = 16'd65000;
  localparam bin_t               LevelBin   = 4'd7;
  localparam bin_t               MidTopBin  = 4'd14;
  localparam bin_t               MidLowBin  = 4'd8;

  localparam logic [ThrW-1:0]  ThrReset   = 12'd2000;
  localparam logic [BandW-1:0] LevelReset = 15'd150;
  localparam logic [BandW-1:0] SteepReset = 15'd5000;

  typedef enum logic [1:0] {
    RegThreshold = 2'd0,
    RegLevelBand = 2'd1,
    RegSteepLvl  = 2'd2,
    RegNone      = 2'd3
  } reg_idx_e;

  localparam logic signed [SampleW-1:0] SteepLimits [NumSteep] = '{
    16'sd300, 16'sd400, 16'sd500, 16'sd600, 16'sd700, 16'sd800, 16'sd900
  };

  localparam logic signed [SampleW-1:0] MidLimits [NumMid] = '{
    16'sd550, 16'sd650, 16'sd725, 16'sd800, 16'sd875, 16'sd940
  };

  typedef struct packed {
    logic keep;  // sample not in the ignored Y range
    logic vote;  // some bin gets a vote
    bin_t bin;
  } sel_t;

endpackage

`default_nettype wire

@@ rtl/core/tbv_bin_sel.sv @@
`default_nettype none

module tbv_bin_sel
  import tbv_pkg::*;
(
  input  var logic signed [SampleW-1:0] accel_y_i,
  input  var logic signed [SampleW-1:0] accel_z_i,
  input  var logic [BandW-1:0]          level_band_i,
  input  var logic [BandW-1:0]          steep_level_i,
  output sel_t                          sel_o
);

  logic [SampleW-1:0] y_raw;
  logic [SampleW-1:0] mag;
  logic               is_level;
  logic               is_steep;
  logic               steep_hit;
  bin_t               steep_bin;
  bin_t               mid_bin;

  assign y_raw    = accel_y_i;
  assign mag      = y_raw[SampleW-1] ? (~y_raw + 16'd1) : y_raw;
  assign is_level = mag < {1'b0, level_band_i};
  assign is_steep = mag > {1'b0, steep_level_i};

  always_comb begin
    steep_hit = 1'b0;
    steep_bin = '0;
    for (int k = NumSteep - 1; k >= 0; k--) begin
      if (accel_z_i < SteepLimits[k]) begin
        steep_hit = 1'b1;
        steep_bin = BinW'(k);
      end
    end
  end

  always_comb begin
    mid_bin = MidLowBin;
    for (int k = NumMid - 1; k >= 0; k--) begin
      if (accel_z_i < MidLimits[k]) begin
        mid_bin = MidTopBin - BinW'(k);
      end
    end
  end

  always_comb begin
    sel_o.keep = y_raw < IgnoreFrom;
    priority if (is_level) begin
      sel_o.vote = 1'b1;
      sel_o.bin  = LevelBin;
    end else if (is_steep) begin
      sel_o.vote = steep_hit;
      sel_o.bin  = steep_bin;
    end else begin
      sel_o.vote = 1'b1;
      sel_o.bin  = mid_bin;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tilt_bin_vote_classifier.sv @@
`default_nettype none

// Tilt bin vote classifier. Each accepted word (one Y/Z sample) is registered,
// then sorted into one of 15 tilt bins (steep samples with Z >= 900 get none)
// and counted; when a bin's count exceeds vote_threshold the bin index leaves on
// the position channel and all counts clear. Samples with Y from -536 to -1 are
// dropped. A position passes the input and result registers; one sample is taken
// every cycle while no position waits unaccepted, the count update and threshold
// scan over all 15 counters being combinational. Registers over APB: 0x0
// vote_threshold, 0x4 level_band, 0x8 steep_level.

module tilt_bin_vote_classifier
  import tbv_pkg::*;
(
  input  var logic                      clk_i,
  input  var logic                      rst_ni,

  input  var logic                      accel_valid_i,
  output var logic                      accel_ready_o,
  input  var logic signed [SampleW-1:0] accel_y_i,
  input  var logic signed [SampleW-1:0] accel_z_i,

  output var logic                      pos_valid_o,
  input  var logic                      pos_ready_i,
  output var logic [BinW-1:0]           position_o,

  input  var logic                      psel,
  input  var logic                      penable,
  input  var logic                      pwrite,
  input  var logic [AddrW-1:0]          paddr,
  input  var logic [DataW-1:0]          pwdata,
  output var logic [DataW-1:0]          prdata,
  output var logic                      pready
);

  logic [ThrW-1:0]  thr_q;
  logic [BandW-1:0] level_q;
  logic [BandW-1:0] steep_q;
  reg_idx_e         reg_idx;

  logic                      s_valid_q;
  logic signed [SampleW-1:0] y_q;
  logic signed [SampleW-1:0] z_q;

  count_t cnt_q [NumBins];
  count_t cnt_n [NumBins];

  logic pos_valid_q;
  bin_t pos_q;

  sel_t sel;
  logic fire;
  logic hit;
  bin_t win;

  // register file
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  assign pready = 1'b1;

  always_comb begin
    unique case (reg_idx)
      RegThreshold: prdata = DataW'(thr_q);
      RegLevelBand: prdata = DataW'(level_q);
      RegSteepLvl:  prdata = DataW'(steep_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= ThrReset;
      level_q <= LevelReset;
      steep_q <= SteepReset;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        RegThreshold: thr_q   <= pwdata[ThrW-1:0];
        RegLevelBand: level_q <= pwdata[BandW-1:0];
        RegSteepLvl:  steep_q <= pwdata[BandW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  assign fire          = s_valid_q && (!pos_valid_q || pos_ready_i);
  assign accel_ready_o = !s_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (accel_ready_o) begin
      s_valid_q <= accel_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accel_ready_o && accel_valid_i) begin
      y_q <= accel_y_i;
      z_q <= accel_z_i;
    end
  end

  tbv_bin_sel u_bin_sel (
    .accel_y_i     (y_q),
    .accel_z_i     (z_q),
    .level_band_i  (level_q),
    .steep_level_i (steep_q),
    .sel_o         (sel)
  );

  // saturating vote, then lowest bin above threshold wins
  always_comb begin
    hit = 1'b0;
    win = '0;
    for (int k = 0; k < NumBins; k++) begin
      cnt_n[k] = cnt_q[k] + CountW'(sel.vote && (sel.bin == BinW'(k))
                                    && (cnt_q[k] != CountMax));
    end
    for (int k = NumBins - 1; k >= 0; k--) begin
      if (cnt_n[k] > thr_q) begin
        hit = 1'b1;
        win = BinW'(k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumBins; k++) begin
        cnt_q[k] <= '0;
      end
    end else if (fire && sel.keep) begin
      for (int k = 0; k < NumBins; k++) begin
        cnt_q[k] <= hit ? '0 : cnt_n[k];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_valid_q <= 1'b0;
    end else if (fire && sel.keep && hit) begin
      pos_valid_q <= 1'b1;
    end else if (pos_ready_i) begin
      pos_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && sel.keep && hit) begin
      pos_q <= win;
    end
  end

  assign pos_valid_o = pos_valid_q;
  assign position_o  = pos_q;

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import tbv_pkg::*;

  typedef enum logic {RowSample, RowWrite} row_kind_e;
  typedef enum logic [1:0] {ChkModel, ChkNone, ChkBin} chk_e;

  typedef struct packed {
    row_kind_e          kind;
    reg_idx_e           ridx;
    logic [15:0]        val;
    logic [SampleW-1:0] y;
    logic [SampleW-1:0] z;
    chk_e               chk;
    bin_t               bin;
  } stim_row_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               accel_valid_i = 1'b0;
  logic               accel_ready_o;
  logic [SampleW-1:0] accel_y_i     = '0;
  logic [SampleW-1:0] accel_z_i     = '0;
  logic               pos_valid_o;
  logic               pos_ready_i   = 1'b0;
  logic [BinW-1:0]    position_o;
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [AddrW-1:0]   paddr         = '0;
  logic [DataW-1:0]   pwdata        = '0;
  logic [DataW-1:0]   prdata;
  logic               pready;

  count_t           votes [NumBins];
  logic [ThrW-1:0]  vote_thr  = ThrReset;
  logic [BandW-1:0] band_lim  = LevelReset;
  logic [BandW-1:0] steep_lim = SteepReset;

  bin_t pos_due [$];
  int   mismatches  = 0;
  bit   no_idle     = 1'b0;
  bit   rx_hold_req = 1'b0;

  stim_row_t dir_rows [27];

  tilt_bin_vote_classifier u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accel_valid_i(accel_valid_i),
    .accel_ready_o(accel_ready_o),
    .accel_y_i    (accel_y_i),
    .accel_z_i    (accel_z_i),
    .pos_valid_o  (pos_valid_o),
    .pos_ready_i  (pos_ready_i),
    .position_o   (position_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Bin vote and threshold scan for one accepted word; returns 1 when a bin wins.
  function automatic logic tally_sample(input logic [SampleW-1:0] y, input logic [SampleW-1:0] z,
                                        output bin_t win);
    int yi, zi, mag, pick;
    logic hit;
    yi   = $signed(y);
    zi   = $signed(z);
    mag  = (yi < 0) ? -yi : yi;
    pick = -1;
    hit  = 1'b0;
    win  = '0;
    if (y >= IgnoreFrom) return 1'b0;
    if (mag < int'(band_lim)) begin
      pick = int'(LevelBin);
    end else if (mag > int'(steep_lim)) begin
      for (int k = NumSteep - 1; k >= 0; k--)
        if (zi < int'(SteepLimits[k])) pick = k;
    end else begin
      pick = int'(MidLowBin);
      for (int k = NumMid - 1; k >= 0; k--)
        if (zi < int'(MidLimits[k])) pick = int'(MidTopBin) - k;
    end
    if (pick >= 0 && votes[pick] != CountMax) votes[pick] = votes[pick] + 1'b1;
    for (int k = 0; k < NumBins; k++) begin
      if (!hit && votes[k] > vote_thr) begin
        hit = 1'b1;
        win = bin_t'(k);
      end
    end
    if (hit)
      for (int k = 0; k < NumBins; k++) votes[k] = '0;
    return hit;
  endfunction

  function automatic stim_row_t smp(input int y, input int z, input chk_e chk, input int bin);
    stim_row_t r;
    r      = '0;
    r.kind = RowSample;
    r.ridx = RegNone;
    r.y    = SampleW'(y);
    r.z    = SampleW'(z);
    r.chk  = chk;
    r.bin  = bin_t'(bin);
    return r;
  endfunction

  function automatic stim_row_t wr(input reg_idx_e ridx, input int val);
    stim_row_t r;
    r      = '0;
    r.kind = RowWrite;
    r.ridx = ridx;
    r.val  = 16'(val);
    r.chk  = ChkNone;
    return r;
  endfunction

  function automatic logic [SampleW-1:0] rand_y();
    int r, m;
    r = $urandom_range(0, 99);
    if (r < 10) return SampleW'($urandom_range(65000, 65535));
    if (r < 30) return SampleW'($urandom);
    case ($urandom_range(0, 2))
      0:       m = int'(band_lim) + int'($urandom_range(0, 4)) - 2;
      1:       m = int'(steep_lim) + int'($urandom_range(0, 4)) - 2;
      default: m = $urandom_range(0, 32768);
    endcase
    if (m < 0) m = 0;
    if (m > 32768) m = 32768;
    return $urandom_range(0, 1) ? SampleW'(-m) : SampleW'(m);
  endfunction

  function automatic logic [SampleW-1:0] rand_z();
    int r, lim;
    if ($urandom_range(0, 3) == 0) return SampleW'($urandom);
    r   = $urandom_range(0, NumSteep + NumMid - 1);
    lim = (r < NumSteep) ? int'(SteepLimits[r]) : int'(MidLimits[r - NumSteep]);
    return SampleW'(lim + int'($urandom_range(0, 4)) - 2);
  endfunction

  task automatic send_word(input logic [SampleW-1:0] y, input logic [SampleW-1:0] z,
                           input chk_e chk, input bin_t fixed_bin);
    bin_t win;
    logic hit;
    while (!no_idle && $urandom_range(0, 99) < 30) begin
      accel_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    accel_valid_i <= 1'b1;
    accel_y_i     <= y;
    accel_z_i     <= z;
    do @(negedge clk_i); while (!accel_ready_o);
    hit = tally_sample(y, z, win);
    case (chk)
      ChkModel: if (hit) pos_due.push_back(win);
      ChkBin:   pos_due.push_back(fixed_bin);
      default:  ;
    endcase
    @(posedge clk_i);
  endtask

  // Sender stops until every position is back and the pipe has emptied.
  task automatic drain();
    accel_valid_i <= 1'b0;
    do @(negedge clk_i); while (pos_due.size() != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e ridx, input int val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({ridx, 2'b00});
    pwdata  <= DataW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    case (ridx)
      RegThreshold: vote_thr  = ThrW'(val);
      RegLevelBand: band_lim  = BandW'(val);
      RegSteepLvl:  steep_lim = BandW'(val);
      default:      ;
    endcase
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // position receiver
  initial begin
    int   hold_left;
    bin_t want;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (pos_valid_o && pos_ready_i) begin
        if (pos_due.size() == 0) begin
          $display("%0t: position expected none, got %0d", $time, position_o);
          mismatches++;
        end else begin
          want = pos_due.pop_front();
          if (position_o !== want) begin
            $display("%0t: position expected %0d, got %0d", $time, want, position_o);
            mismatches++;
          end
        end
      end
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        pos_ready_i <= 1'b0;
      end else begin
        pos_ready_i <= no_idle || ($urandom_range(0, 99) >= 30);
      end
    end
  end

  initial begin
    bit apb_open, after_word;
    int t, b, s;
    apb_open   = 1'b0;
    after_word = 1'b0;
    for (int k = 0; k < NumBins; k++) votes[k] = '0;
    dir_rows = '{
      smp(0, 0, ChkNone, 0),
      smp(-1, 0, ChkNone, 0),
      smp(-536, 0, ChkNone, 0),
      smp(-537, 0, ChkNone, 0),
      wr(RegThreshold, 0),
      smp(-32768, 32767, ChkModel, 0),
      smp(32767, -32768, ChkBin, 0),
      smp(-32768, 300, ChkBin, 1),
      smp(5001, 899, ChkBin, 6),
      smp(5001, 900, ChkNone, 0),
      smp(5000, 549, ChkBin, 14),
      smp(1000, 550, ChkBin, 13),
      smp(1000, 939, ChkBin, 9),
      smp(-1000, 940, ChkBin, 8),
      smp(1000, 32767, ChkBin, 8),
      smp(149, -32768, ChkBin, 7),
      smp(-149, 1234, ChkNone, 0),
      smp(150, 0, ChkBin, 14),
      wr(RegLevelBand, 0),
      wr(RegSteepLvl, 32767),
      smp(0, 0, ChkBin, 14),
      smp(-32768, 0, ChkBin, 0),
      smp(32767, 0, ChkBin, 14),
      wr(RegThreshold, 1),
      smp(32767, 32767, ChkModel, 0),
      smp(-300, 0, ChkNone, 0),
      smp(32767, 32767, ChkModel, 0)
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowWrite) begin
        if (after_word) drain();
        after_word = 1'b0;
        write_reg(dir_rows[i].ridx, int'(dir_rows[i].val));
        apb_open = 1'b1;
      end else begin
        if (apb_open) apb_release();
        apb_open   = 1'b0;
        after_word = 1'b1;
        send_word(dir_rows[i].y, dir_rows[i].z, dir_rows[i].chk, dir_rows[i].bin);
      end
    end

    // level counter driven into saturation, then released by a lower threshold
    drain();
    write_reg(RegThreshold, 4095);
    write_reg(RegLevelBand, 32767);
    apb_release();
    no_idle = 1'b1;
    repeat (4100) send_word(SampleW'($urandom_range(0, 32766)), rand_z(), ChkModel, '0);
    drain();
    write_reg(RegThreshold, 4094);
    apb_release();
    send_word(SampleW'(100), rand_z(), ChkModel, '0);
    no_idle = 1'b0;

    for (int ph = 0; ph < 10; ph++) begin
      drain();
      case (ph)
        0: begin t = 0;    b = 150;   s = 5000;  end
        1: begin t = 4094; b = 0;     s = 0;     end
        2: begin t = 3;    b = 32767; s = 32767; end
        default: begin
          t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4094) : $urandom_range(0, 12);
          case ($urandom_range(0, 3))
            0:       b = 150;
            1:       b = $urandom_range(0, 2000);
            2:       b = $urandom_range(0, 32767);
            default: b = 0;
          endcase
          case ($urandom_range(0, 3))
            0:       s = 5000;
            1:       s = b + $urandom_range(0, 8000);
            2:       s = $urandom_range(0, 32767);
            default: s = 32767;
          endcase
          if (s > 32767) s = 32767;
        end
      endcase
      write_reg(RegThreshold, t);
      write_reg(RegLevelBand, b);
      write_reg(RegSteepLvl, s);
      apb_release();
      if (ph == 0) rx_hold_req = 1'b1;
      repeat (52) send_word(rand_y(), rand_z(), ChkModel, '0);
    end

    drain();
    if (mismatches == 0 && pos_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/tbv_pkg.sv
rtl/core/tbv_bin_sel.sv
rtl/core/tilt_bin_vote_classifier.sv
bench/tb.sv
